>>> sv/u8dfa_pkg.sv
`default_nettype none

package u8dfa_pkg;

    // Widths of the stream fields and of the decoder state.
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned STATE_W = 4;
    localparam int unsigned CLASS_W = 4;
    localparam int unsigned NUM_STATES = 9;
    localparam int unsigned NUM_CLASSES = 16;

    // Payload bits carried by one continuation byte.
    localparam int unsigned CONT_BITS = 6;

    typedef logic [STATE_W-1:0] t_state;
    typedef logic [CLASS_W-1:0] t_class;
    typedef logic [CP_W-1:0]    t_code_point;

    // Named DFA states.
    localparam t_state ST_ACCEPT = 4'd0;
    localparam t_state ST_REJECT = 4'd1;

    // Code point given out for a malformed sequence.
    localparam t_code_point REPLACEMENT = 21'h00FFFD;
    // Largest Unicode scalar value.
    localparam t_code_point MAX_SCALAR = 21'h10FFFF;

    // Result of decoding one byte.
    typedef struct packed {
        logic        valid;
        logic        is_error;
        t_code_point code_point;
    } t_step_result;

    // Next state, indexed [state][class].
    localparam t_state NEXT_STATE [NUM_STATES][NUM_CLASSES] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1,
          4'd1, 4'd1, 4'd4, 4'd6, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
          4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0,
          4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
          4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
          4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
          4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
          4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
          4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
          4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
    };

    // Character class of a raw byte.
    function automatic t_class byte_class(input logic [BYTE_W-1:0] b);
        t_class cls;
        case (b) inside
            [8'h00:8'h7F]: cls = 4'd0;
            [8'h80:8'h8F]: cls = 4'd1;
            [8'h90:8'h9F]: cls = 4'd9;
            [8'hA0:8'hBF]: cls = 4'd7;
            [8'hC0:8'hC1]: cls = 4'd8;
            [8'hC2:8'hDF]: cls = 4'd2;
            8'hE0:         cls = 4'd10;
            [8'hE1:8'hEC]: cls = 4'd3;
            8'hED:         cls = 4'd4;
            [8'hEE:8'hEF]: cls = 4'd3;
            8'hF0:         cls = 4'd11;
            [8'hF1:8'hF3]: cls = 4'd6;
            8'hF4:         cls = 4'd5;
            default:       cls = 4'd8;
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

>>> sv/utf8_dfa_decoder.sv
// UTF-8 stream decoder.
// Bytes enter on the s_axis channel, one byte per transaction in
// s_axis_tdata[7:0]. Decoded code points leave on the m_axis channel:
// m_axis_tdata[20:0] holds the code point, m_axis_tuser[0] marks a
// malformed sequence, for which the code point is U+FFFD.
// A byte that completes a sequence or breaks one gives one output
// transaction; a byte inside a sequence gives none. The byte that breaks a
// sequence is consumed, and decoding restarts at the next byte.
// Pipeline: a byte is captured in the input register, where the class
// lookup, the next state and the accumulator update are formed, and its
// result is then loaded into the output register that drives m_axis_tvalid.
// Throughput: one byte per cycle while results are taken, set by the loop
// from the decoder state register through the transition table and back.
// Reset clears the decoder to the start state and empties both registers.
// A sequence cut off by the end of the stream stays pending.
// When the receiver stalls, the result is held; the input register still
// takes bytes that give no result, and s_axis_tready drops once a byte
// with a result waits behind the held one.
`default_nettype none

module utf8_dfa_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic [0:0]       m_axis_tuser    // [0] is_error
);

    logic                         r_in_valid;
    logic [u8dfa_pkg::BYTE_W-1:0] r_in_byte;
    u8dfa_pkg::t_state            r_state;
    u8dfa_pkg::t_code_point       r_acc;
    logic                         r_out_valid;
    logic                         r_out_err;
    u8dfa_pkg::t_code_point       r_out_cp;

    u8dfa_pkg::t_state            w_state;
    u8dfa_pkg::t_code_point       w_acc;
    u8dfa_pkg::t_step_result      w_result;
    logic                         w_out_free;
    logic                         w_advance;
    logic                         w_load;

    u8dfa_step u_step (
        .i_byte   (r_in_byte),
        .i_state  (r_state),
        .i_acc    (r_acc),
        .o_state  (w_state),
        .o_acc    (w_acc),
        .o_result (w_result)
    );

    // The held byte moves on when it gives no result or the output has room.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && (!w_result.valid || w_out_free);
    assign w_load        = w_advance && w_result.valid;
    assign s_axis_tready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // Decoder state and accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= u8dfa_pkg::ST_ACCEPT;
            r_acc   <= '0;
        end else if (w_advance) begin
            r_state <= w_state;
            r_acc   <= w_acc;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_load) begin
            r_out_err <= w_result.is_error;
            r_out_cp  <= w_result.code_point;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(24-u8dfa_pkg::CP_W){1'b0}}, r_out_cp};
    assign m_axis_tuser  = r_out_err;

    // The decoder never rests in reject or in a state past the table.
    a_state_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != u8dfa_pkg::ST_REJECT) &&
        (r_state < 4'(u8dfa_pkg::NUM_STATES)))
        else $error("decoder state out of range");

    // Any byte that gives a result leaves the decoder in the start state.
    a_result_restarts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_state == u8dfa_pkg::ST_ACCEPT))
        else $error("decoder not at start after a result");

    // An error result always carries the replacement code point.
    a_error_value : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_cp == u8dfa_pkg::REPLACEMENT))
        else $error("error result without replacement code point");

    // A good result is a Unicode scalar value.
    a_scalar_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_err) |-> (r_out_cp <= u8dfa_pkg::MAX_SCALAR))
        else $error("decoded value beyond the Unicode range");

    // A held result is not overwritten while the receiver stalls.
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !w_load)
        else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

>>> sv/u8dfa_step.sv
`default_nettype none

// One DFA step: classify the byte, look up the next state and fold the
// payload bits into the accumulator.
module u8dfa_step (
    input  wire logic [u8dfa_pkg::BYTE_W-1:0] i_byte,
    input  wire u8dfa_pkg::t_state            i_state,
    input  wire u8dfa_pkg::t_code_point       i_acc,
    output u8dfa_pkg::t_state                 o_state,
    output u8dfa_pkg::t_code_point            o_acc,
    output u8dfa_pkg::t_step_result           o_result
);

    u8dfa_pkg::t_class      w_class;
    u8dfa_pkg::t_state      w_next;
    u8dfa_pkg::t_code_point w_acc;
    logic [u8dfa_pkg::BYTE_W-1:0] w_lead_mask;

    assign w_class = u8dfa_pkg::byte_class(i_byte);

    // Lead byte keeps the bits under its length prefix; the mask shifts out
    // completely for classes of eight and up.
    assign w_lead_mask = 8'hFF >> w_class;

    // A continuation byte adds six payload bits; a lead byte starts over.
    always_comb begin
        if (i_state != u8dfa_pkg::ST_ACCEPT) begin
            w_acc = {i_acc[u8dfa_pkg::CP_W-u8dfa_pkg::CONT_BITS-1:0],
                     i_byte[u8dfa_pkg::CONT_BITS-1:0]};
        end else begin
            w_acc = {{(u8dfa_pkg::CP_W-u8dfa_pkg::BYTE_W){1'b0}},
                     w_lead_mask & i_byte};
        end
    end

    // State values past the table lead to reject on every class.
    always_comb begin
        if (i_state < 4'(u8dfa_pkg::NUM_STATES)) begin
            w_next = u8dfa_pkg::NEXT_STATE[i_state][w_class];
        end else begin
            w_next = u8dfa_pkg::ST_REJECT;
        end
    end

    // Accept gives the code point, reject gives the replacement and restarts.
    always_comb begin
        o_result.valid      = 1'b0;
        o_result.is_error   = 1'b0;
        o_result.code_point = w_acc;
        o_state             = w_next;
        o_acc               = w_acc;
        case (w_next)
            u8dfa_pkg::ST_ACCEPT: begin
                o_result.valid = 1'b1;
            end
            u8dfa_pkg::ST_REJECT: begin
                o_result.valid      = 1'b1;
                o_result.is_error   = 1'b1;
                o_result.code_point = u8dfa_pkg::REPLACEMENT;
                o_state             = u8dfa_pkg::ST_ACCEPT;
                o_acc               = '0;
            end
            default: begin
                o_result.valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> tb/utf8_dfa_decoder_checker.sv
`default_nettype none

module utf8_dfa_decoder_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    input  wire logic [0:0]  m_axis_tuser,   // [0] is_error
    output int               o_pending,
    output int               o_fail_count,
    output int               o_result_count,
    output int               o_error_count
);

    // Character classes of the decoding table.
    localparam logic [3:0] CLS_ASCII    = 4'd0;   // 00..7F
    localparam logic [3:0] CLS_CONT_LO  = 4'd1;   // 80..8F
    localparam logic [3:0] CLS_LEAD2    = 4'd2;   // C2..DF
    localparam logic [3:0] CLS_LEAD3    = 4'd3;   // E1..EC, EE..EF
    localparam logic [3:0] CLS_LEAD_ED  = 4'd4;   // ED
    localparam logic [3:0] CLS_LEAD_F4  = 4'd5;   // F4
    localparam logic [3:0] CLS_LEAD4    = 4'd6;   // F1..F3
    localparam logic [3:0] CLS_CONT_HI  = 4'd7;   // A0..BF
    localparam logic [3:0] CLS_INVALID  = 4'd8;   // C0..C1, F5..FF
    localparam logic [3:0] CLS_CONT_MID = 4'd9;   // 90..9F
    localparam logic [3:0] CLS_LEAD_E0  = 4'd10;  // E0
    localparam logic [3:0] CLS_LEAD_F0  = 4'd11;  // F0

    localparam int unsigned DFA_STATES = 9;
    localparam u8dfa_pkg::t_code_point REPLACEMENT_CP = 21'h00FFFD;

    // Transition table, indexed [state][class].
    localparam u8dfa_pkg::t_state DFA_NEXT [DFA_STATES][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1,
          4'd1, 4'd1, 4'd4, 4'd6, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
          4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0,
          4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
          4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
          4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
          4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
          4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
          4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
          4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
    };

    typedef struct packed {
        u8dfa_pkg::t_code_point code_point;
        logic                   is_error;
    } t_decoded_char;

    t_decoded_char          pending_chars [$];
    t_decoded_char          want;
    t_decoded_char          got;
    u8dfa_pkg::t_state      dfa_state;
    u8dfa_pkg::t_state      dfa_next_state;
    u8dfa_pkg::t_code_point code_acc;
    logic [3:0]             cls;
    logic [7:0]             lead_mask;
    int                     fails;
    int                     results_seen;
    int                     errors_seen;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dfa_state = u8dfa_pkg::ST_ACCEPT;
            code_acc = '0;
            pending_chars.delete();
            fails = 0;
            results_seen = 0;
            errors_seen = 0;
        end else begin
            // Compare each output transaction with the oldest predicted character.
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (m_axis_tuser[0] === 1'b1) begin
                    errors_seen++;
                end
                got.code_point = m_axis_tdata[20:0];
                got.is_error = m_axis_tuser[0];
                if (pending_chars.size() == 0) begin
                    $error("Unexpected result: code_point %06h is_error %0b",
                           got.code_point, got.is_error);
                    fails++;
                end else begin
                    want = pending_chars.pop_front();
                    if (got.code_point !== want.code_point) begin
                        $error("Field code_point: expected %06h, actual %06h",
                               want.code_point, got.code_point);
                        fails++;
                    end
                    if (got.is_error !== want.is_error) begin
                        $error("Field is_error: expected %0b, actual %0b",
                               want.is_error, got.is_error);
                        fails++;
                    end
                    if (m_axis_tdata[23:21] !== 3'b000) begin
                        $error("Field tdata padding: expected 0, actual %0h",
                               m_axis_tdata[23:21]);
                        fails++;
                    end
                end
            end

            // Run every accepted byte through the decoding automaton.
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tdata <= 8'h7F) cls = CLS_ASCII;
                else if (s_axis_tdata <= 8'h8F) cls = CLS_CONT_LO;
                else if (s_axis_tdata <= 8'h9F) cls = CLS_CONT_MID;
                else if (s_axis_tdata <= 8'hBF) cls = CLS_CONT_HI;
                else if (s_axis_tdata <= 8'hC1) cls = CLS_INVALID;
                else if (s_axis_tdata <= 8'hDF) cls = CLS_LEAD2;
                else if (s_axis_tdata == 8'hE0) cls = CLS_LEAD_E0;
                else if (s_axis_tdata == 8'hED) cls = CLS_LEAD_ED;
                else if (s_axis_tdata <= 8'hEF) cls = CLS_LEAD3;
                else if (s_axis_tdata == 8'hF0) cls = CLS_LEAD_F0;
                else if (s_axis_tdata <= 8'hF3) cls = CLS_LEAD4;
                else if (s_axis_tdata == 8'hF4) cls = CLS_LEAD_F4;
                else cls = CLS_INVALID;

                // A lead byte keeps only its payload bits; a continuation shifts in six.
                if (dfa_state != u8dfa_pkg::ST_ACCEPT) begin
                    code_acc = {code_acc[14:0], s_axis_tdata[5:0]};
                end else begin
                    lead_mask = 8'hFF >> cls;
                    code_acc = {13'd0, lead_mask & s_axis_tdata};
                end

                if (dfa_state < DFA_STATES) dfa_next_state = DFA_NEXT[dfa_state][cls];
                else dfa_next_state = u8dfa_pkg::ST_REJECT;

                if (dfa_next_state == u8dfa_pkg::ST_ACCEPT) begin
                    dfa_state = u8dfa_pkg::ST_ACCEPT;
                    want.code_point = code_acc;
                    want.is_error = 1'b0;
                    pending_chars.push_back(want);
                end else if (dfa_next_state == u8dfa_pkg::ST_REJECT) begin
                    // The offending byte is dropped and decoding restarts.
                    dfa_state = u8dfa_pkg::ST_ACCEPT;
                    code_acc = '0;
                    want.code_point = REPLACEMENT_CP;
                    want.is_error = 1'b1;
                    pending_chars.push_back(want);
                end else begin
                    dfa_state = dfa_next_state;
                end
            end
        end
        o_pending <= pending_chars.size();
        o_fail_count <= fails;
        o_result_count <= results_seen;
        o_error_count <= errors_seen;
    end

endmodule

`default_nettype wire

>>> tb/utf8_dfa_decoder_tb.sv
`default_nettype none

module utf8_dfa_decoder_tb;

    localparam int unsigned RANDOM_BYTES = 850;
    localparam int unsigned IDLE_LIMIT   = 1000;
    localparam int unsigned TAIL_CYCLES  = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    int          pending;
    int          fail_count;
    int          result_count;
    int          error_count;

    logic [7:0]  byte_plan [$];
    bit          calm = 1'b0;
    int unsigned idle_cycles = 0;
    int unsigned sent_count = 0;
    int unsigned directed_count = 0;

    always #5 i_clk = ~i_clk;

    utf8_dfa_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    utf8_dfa_decoder_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .o_pending      (pending),
        .o_fail_count   (fail_count),
        .o_result_count (result_count),
        .o_error_count  (error_count)
    );

    // Mostly no gap or a short one, now and then a long one; none in calm stretches.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Encode a scalar value as UTF-8 and queue its first keep bytes.
    task automatic push_utf8(input logic [20:0] cp, input int unsigned keep);
        logic [7:0]  enc [4];
        int unsigned n;
        if (cp < 21'h80) begin
            enc[0] = {1'b0, cp[6:0]};
            n = 1;
        end else if (cp < 21'h800) begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
            n = 2;
        end else if (cp < 21'h10000) begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
            n = 3;
        end else begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
            n = 4;
        end
        for (int unsigned k = 0; k < n && k < keep; k++) begin
            byte_plan.push_back(enc[k]);
        end
    endtask

    // Offer one byte after a random gap and hold it until the transaction completes.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_count++;
    endtask

    // Stop sending until every predicted character has come out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Receiver: random stalls, short and long, or always ready in calm stretches.
    initial begin
        int unsigned stall;
        forever begin
            if (calm) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // Watchdog: too long without any transaction on either side ends the run.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Stimulus: directed sequences, then random traffic with a drain in the middle.
    initial begin
        int unsigned r;
        int unsigned len;
        int unsigned pause_at;
        logic [20:0] cp;

        // Range extremes of each sequence length.
        push_utf8(21'h000000, 4);
        push_utf8(21'h00007F, 4);
        push_utf8(21'h000080, 4);
        push_utf8(21'h0007FF, 4);
        push_utf8(21'h000800, 4);
        push_utf8(21'h00FFFF, 4);
        push_utf8(21'h010000, 4);
        push_utf8(21'h10FFFF, 4);
        // Lone continuation, overlong lead, byte above F4.
        byte_plan.push_back(8'h80);
        byte_plan.push_back(8'hC0);
        byte_plan.push_back(8'hFF);
        // Surrogate, above U+10FFFF, overlong three-byte form.
        byte_plan.push_back(8'hED);
        byte_plan.push_back(8'hA0);
        byte_plan.push_back(8'hF4);
        byte_plan.push_back(8'h90);
        byte_plan.push_back(8'hE0);
        byte_plan.push_back(8'h80);
        // A sequence broken by an ASCII byte, which is consumed with the error.
        byte_plan.push_back(8'hC2);
        byte_plan.push_back(8'h41);
        directed_count = byte_plan.size();

        // Mostly well-formed characters, some noise and cut-off sequences.
        while (byte_plan.size() < directed_count + RANDOM_BYTES) begin
            r = $urandom_range(0, 99);
            len = $urandom_range(1, 4);
            case (len)
                1: cp = 21'($urandom_range(21'h0, 21'h7F));
                2: cp = 21'($urandom_range(21'h80, 21'h7FF));
                3: begin
                    cp = 21'($urandom_range(21'h800, 21'hFFFF));
                    if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h1000;
                end
                default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
            endcase
            if (r < 70) begin
                push_utf8(cp, 4);
            end else if (r < 85 || len == 1) begin
                byte_plan.push_back(8'($urandom_range(0, 255)));
            end else begin
                push_utf8(cp, $urandom_range(1, len - 1));
                byte_plan.push_back(8'($urandom_range(0, 255)));
            end
        end
        // The stream ends inside a three-byte sequence, which stays pending.
        byte_plan.push_back(8'hE1);
        byte_plan.push_back(8'h80);
        pause_at = directed_count + (byte_plan.size() - directed_count) / 2;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int unsigned i = 0; i < byte_plan.size(); i++) begin
            if (i % 97 == 0) calm = ($urandom_range(0, 3) == 0);
            if (i == pause_at) drain_results();
            send_byte(byte_plan[i]);
        end
        calm = 1'b0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes (%0d directed), with stalls on both sides and a mid-run drain.",
                 sent_count, directed_count);
        $display("Checked %0d decoded characters, %0d of them replacements for malformed input.",
                 result_count, error_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> utf8_dfa_decoder.f
sv/u8dfa_pkg.sv
sv/u8dfa_step.sv
sv/utf8_dfa_decoder.sv
tb/utf8_dfa_decoder_checker.sv
tb/utf8_dfa_decoder_tb.sv
